FILE: hw/rtl/lfra_pkg.sv
// Shared constants, payload types and helpers for the lowest-free room allocator.
package lfra_pkg;

  localparam int MAX_ROOMS  = 16;
  localparam int ROOM_IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ROOMS + 1);
  localparam int TIME_W     = 40;
  localparam int COUNT_W    = 32;
  localparam int CFG_W      = 5;
  localparam int ROOM_FIELD_W = 4;

  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   ROOMS_RESET = CFG_W'(16);

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic        last_booking;
  } booking_t;

  typedef struct packed {
    logic [ROOM_FIELD_W-1:0] assigned_room;
    logic [TIME_W-1:0]       actual_start;
    logic [TIME_W-1:0]       actual_end;
    logic [ROOM_FIELD_W-1:0] busiest_room;
    logic                    report_valid;
  } result_t;

  // room index to the fixed-width result field
  function automatic logic [ROOM_FIELD_W-1:0] room_field(logic [ROOM_IDX_W-1:0] r);
    logic [31:0] w;
    w = 32'(r);
    return w[ROOM_FIELD_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/lowest_free_room_allocator.sv
// Lowest-free room allocator: top level with scan sequencer and room state RAMs.
//
// Each booking is placed in the lowest-numbered active room whose free time is at or
// before its start, else in the room that frees first (lowest index on a tie), delayed
// to keep its duration. Room free times and booking counts live in two 16-entry RAMs
// with registered reads; a per-room valid bit makes unwritten rooms read as zero, so
// reset and batch end clear the state at once with no clearing pass. A booking is
// worked by a one-room-per-cycle read scan of the free-time RAM over the k active
// rooms (k = active room count, 1..16), then a read-modify-write of the chosen room.
// A booking marked last then adds a scan of all 16 rooms of the count RAM for the
// busiest-room report. One result is produced per booking; a finished result waits
// in the output register while the next booking is accepted and worked.
module lowest_free_room_allocator
  import lfra_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  booking_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_BOOK   = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]            state;
  logic [CFG_W-1:0]      rooms_in_use;
  logic [MAX_ROOMS-1:0]  valid;

  logic [CNT_W-1:0]      iss;
  logic [CNT_W-1:0]      scan_lim;
  logic                  pend;
  logic [ROOM_IDX_W-1:0] pend_idx;

  logic [TIME_W-1:0]     start_q;
  logic [31:0]           dur_q;
  logic                  last_q;

  logic                  found;
  logic [ROOM_IDX_W-1:0] pick_free;
  logic [ROOM_IDX_W-1:0] min_idx;
  logic [TIME_W-1:0]     min_val;
  logic [ROOM_IDX_W-1:0] pick;
  logic [TIME_W-1:0]     act_start;
  logic [COUNT_W-1:0]    best;
  logic [ROOM_IDX_W-1:0] bus_idx;
  result_t               res;

  logic                  vld_free_q;
  logic                  vld_bk_q;
  logic [TIME_W-1:0]     free_rdata;
  logic [COUNT_W-1:0]    bk_rdata;
  logic [TIME_W-1:0]     free_eff;
  logic [COUNT_W-1:0]    bk_eff;
  logic [ROOM_IDX_W-1:0] free_raddr;
  logic [ROOM_IDX_W-1:0] bk_raddr;
  logic                  ram_we;
  logic [TIME_W-1:0]     act_end;
  logic [TIME_W:0]       end_sum;
  logic [COUNT_W-1:0]    cnt_inc;
  logic [ROOM_IDX_W-1:0] pick_sel;
  logic [CNT_W-1:0]      k_in;
  logic                  scan_done;
  logic                  in_acc;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // clamp the room count to 1..MAX_ROOMS
  always_comb begin
    if (rooms_in_use > CFG_W'(MAX_ROOMS)) begin
      k_in = CNT_W'(MAX_ROOMS);
    end else if (rooms_in_use == '0) begin
      k_in = CNT_W'(1);
    end else begin
      k_in = CNT_W'(rooms_in_use);
    end
  end

  assign free_eff  = vld_free_q ? free_rdata : '0;
  assign bk_eff    = vld_bk_q ? bk_rdata : '0;
  assign pick_sel  = found ? pick_free : min_idx;
  assign free_raddr = iss[ROOM_IDX_W-1:0];
  assign bk_raddr  = (state == S_BOOK) ? pick_sel : iss[ROOM_IDX_W-1:0];
  assign scan_done = (iss == scan_lim) && !pend;
  assign ram_we    = (state == S_WRITE);

  assign end_sum = {1'b0, act_start} + (TIME_W + 1)'(dur_q);
  assign act_end = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
  assign cnt_inc = (bk_eff == COUNT_MAX) ? bk_eff : bk_eff + COUNT_W'(1);

  lfra_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ROOMS)) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick),
    .wdata (act_end),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  lfra_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_ROOMS)) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick),
    .wdata (cnt_inc),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rooms_in_use <= ROOMS_RESET;
      valid        <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      vld_free_q <= valid[free_raddr];
      vld_bk_q   <= valid[bk_raddr];

      if (cfg_we) begin
        rooms_in_use <= cfg_wdata;
      end
      // S_OUT handles out_valid itself
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      // shared read-issue sequencer for both scans
      if (state == S_SCAN || state == S_REPORT) begin
        if (iss < scan_lim) begin
          iss      <= iss + CNT_W'(1);
          pend     <= 1'b1;
          pend_idx <= iss[ROOM_IDX_W-1:0];
        end else begin
          pend <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            start_q  <= TIME_W'(in_data.start_time);
            dur_q    <= (in_data.end_time > in_data.start_time) ?
                        in_data.end_time - in_data.start_time : '0;
            last_q   <= in_data.last_booking;
            scan_lim <= k_in;
            iss      <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pend) begin
            if (!found && free_eff <= start_q) begin
              found     <= 1'b1;
              pick_free <= pend_idx;
            end
            if (pend_idx == '0 || free_eff < min_val) begin
              min_val <= free_eff;
              min_idx <= pend_idx;
            end
          end
          if (scan_done) begin
            state <= S_BOOK;
          end
        end
        S_BOOK: begin
          // count RAM read of the chosen room is issued here
          pick      <= pick_sel;
          act_start <= found ? start_q : min_val;
          state     <= S_WRITE;
        end
        S_WRITE: begin
          valid[pick]       <= 1'b1;
          res.assigned_room <= room_field(pick);
          res.actual_start  <= act_start;
          res.actual_end    <= act_end;
          res.busiest_room  <= '0;
          res.report_valid  <= 1'b0;
          if (last_q) begin
            iss      <= '0;
            pend     <= 1'b0;
            scan_lim <= CNT_W'(MAX_ROOMS);
            best     <= '0;
            bus_idx  <= '0;
            state    <= S_REPORT;
          end else begin
            state <= S_OUT;
          end
        end
        S_REPORT: begin
          if (pend && bk_eff > best) begin
            best    <= bk_eff;
            bus_idx <= pend_idx;
          end
          if (scan_done) begin
            res.busiest_room <= room_field(bus_idx);
            res.report_valid <= 1'b1;
            valid            <= '0;
            state            <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the chosen room always lies inside the active range
  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (CNT_W'(pick) < scan_lim))
    else $error("room pick outside active range");

  // batch end leaves every room cleared
  a_clear_after_report: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPORT && scan_done) |=> (valid == '0))
    else $error("room state not cleared after report");

  // delayed or not, a booking never ends before it starts
  a_end_after_start: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.actual_end >= out_data.actual_start))
    else $error("actual_end before actual_start");

  // busiest room is zero unless the result closes a batch
  a_busiest_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.report_valid) |-> (out_data.busiest_room == '0))
    else $error("busiest_room set without report");

  // a written room reads back as valid on the next scan
  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && !last_q) |=> valid[$past(pick)])
    else $error("written room not marked valid");

endmodule

FILE: hw/rtl/lfra_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module lfra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
